// ===== hdl/mmpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpwm_pkg
// Command codes, the power level table and the types shared between the
// motor controller top level and its per-motor cells.
// ----------------------------------------------------------------------------
package mmpwm_pkg;

  // command codes on the input channel
  typedef enum logic [3:0] {
    CMD_TICK     = 4'd0,
    CMD_SELECT   = 4'd1,
    CMD_ON       = 4'd2,
    CMD_OFF      = 4'd3,
    CMD_REVERSE  = 4'd4,
    CMD_THISWAY  = 4'd5,
    CMD_THATWAY  = 4'd6,
    CMD_COAST    = 4'd7,
    CMD_POWER    = 4'd8,
    CMD_ADDPOWER = 4'd9,
    CMD_SERVO    = 4'd10
  } cmd_t;

  // pwm period runs over steps 0 .. PWM_LAST_STEP
  localparam logic [7:0] PWM_LAST_STEP = 8'd254;
  localparam logic [7:0] DUTY_FULL     = 8'd255;

  // power levels 1..7 map to these duties, other values are taken raw
  localparam logic [7:0] POWER_TABLE [8] = '{
    8'd0, 8'd36, 8'd73, 8'd110, 8'd146, 8'd183, 8'd219, 8'd255
  };

  // control broadcast from the top level to every motor cell
  typedef struct packed {
    logic       go;     // beat accepted this cycle
    logic [3:0] cmd;
    logic [7:0] value;
    logic [7:0] step;   // pwm step the tick processes
  } motor_ctl_t;

  // per-motor status back to the top level
  typedef struct packed {
    logic on;
    logic cw;
    logic ccw;
    logic en;
  } motor_stat_t;

  // map a power command value to a duty
  function automatic logic [7:0] power_duty(input logic [7:0] value);
    logic [7:0] d;
    if (value >= 8'd1 && value <= 8'd7) begin
      d = POWER_TABLE[value[2:0]];
    end else begin
      d = value;
    end
    return d;
  endfunction

endpackage

// ===== hdl/mmpwm_motor.sv =====
// ----------------------------------------------------------------------------
// mmpwm_motor
// One motor channel: on, direction and servo bits, the 8-bit duty and the
// bridge pin levels, updated by one command beat at a time.
// ----------------------------------------------------------------------------
module mmpwm_motor
  import mmpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  motor_ctl_t  ctl,
  input  logic        sel,
  output motor_stat_t stat
);

  logic       on_r, on_nxt;
  logic       dir_r, dir_nxt;
  logic       servo_r, servo_nxt;
  logic       cw_r, cw_nxt;
  logic       ccw_r, ccw_nxt;
  logic       en_r, en_nxt;
  logic [7:0] duty_r, duty_nxt;
  logic       pin_hit;
  logic       pin_lvl;

  // pwm edge for this step: fall at the duty step, rise at step zero
  always_comb begin
    pin_hit = 1'b0;
    pin_lvl = 1'b0;
    if (duty_r != DUTY_FULL && duty_r == ctl.step) begin
      pin_hit = 1'b1;
      pin_lvl = 1'b0;
    end else if (ctl.step == 8'd0 && duty_r != 8'd0) begin
      pin_hit = 1'b1;
      pin_lvl = 1'b1;
    end
  end

  // command decode
  always_comb begin
    on_nxt    = on_r;
    dir_nxt   = dir_r;
    servo_nxt = servo_r;
    cw_nxt    = cw_r;
    ccw_nxt   = ccw_r;
    en_nxt    = en_r;
    duty_nxt  = duty_r;
    if (ctl.go) begin
      unique case (ctl.cmd)
        CMD_TICK: begin
          if (on_r && pin_hit) begin
            if (!servo_r && dir_r) begin
              cw_nxt = pin_lvl;
            end else begin
              ccw_nxt = pin_lvl;
            end
          end
        end
        CMD_ON: begin
          if (sel) begin
            servo_nxt = 1'b0;
            cw_nxt    = dir_r;
            ccw_nxt   = !dir_r;
            en_nxt    = 1'b1;
            on_nxt    = 1'b1;
          end
        end
        CMD_OFF: begin
          if (sel) begin
            servo_nxt = 1'b0;
            cw_nxt    = 1'b1;
            ccw_nxt   = 1'b1;
            en_nxt    = 1'b0;
            on_nxt    = 1'b0;
          end
        end
        CMD_REVERSE: begin
          if (sel) begin
            servo_nxt = 1'b0;
            dir_nxt   = !dir_r;
            cw_nxt    = !dir_r;
            ccw_nxt   = dir_r;
          end
        end
        CMD_THISWAY: begin
          if (sel) begin
            servo_nxt = 1'b0;
            dir_nxt   = 1'b1;
            cw_nxt    = 1'b1;
            ccw_nxt   = 1'b0;
          end
        end
        CMD_THATWAY: begin
          if (sel) begin
            servo_nxt = 1'b0;
            dir_nxt   = 1'b0;
            cw_nxt    = 1'b0;
            ccw_nxt   = 1'b1;
          end
        end
        CMD_COAST: begin
          if (sel) begin
            servo_nxt = 1'b0;
            on_nxt    = 1'b0;
            cw_nxt    = 1'b0;
            ccw_nxt   = 1'b0;
          end
        end
        CMD_POWER: begin
          if (sel) begin
            duty_nxt = power_duty(ctl.value);
          end
        end
        CMD_ADDPOWER: begin
          if (sel) begin
            duty_nxt = duty_r + ctl.value;
          end
        end
        CMD_SERVO: begin
          // on, then thisway, then servo bit and power
          if (sel) begin
            on_nxt    = 1'b1;
            en_nxt    = 1'b1;
            dir_nxt   = 1'b1;
            cw_nxt    = 1'b1;
            ccw_nxt   = 1'b0;
            servo_nxt = 1'b1;
            duty_nxt  = power_duty(ctl.value);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b0;
      dir_r   <= 1'b0;
      servo_r <= 1'b0;
      cw_r    <= 1'b0;
      ccw_r   <= 1'b0;
      en_r    <= 1'b0;
      duty_r  <= DUTY_FULL;
    end else begin
      on_r    <= on_nxt;
      dir_r   <= dir_nxt;
      servo_r <= servo_nxt;
      cw_r    <= cw_nxt;
      ccw_r   <= ccw_nxt;
      en_r    <= en_nxt;
      duty_r  <= duty_nxt;
    end
  end

  assign stat.on  = on_r;
  assign stat.cw  = cw_r;
  assign stat.ccw = ccw_r;
  assign stat.en  = en_r;

endmodule

// ===== hdl/multi_motor_pwm_hbridge_controller.sv =====
// ----------------------------------------------------------------------------
// multi_motor_pwm_hbridge_controller
// Multi-channel H-bridge motor driver with a 255-step synchronous PWM.
// ----------------------------------------------------------------------------
// Every accepted command beat updates the motor state in the cycle it is taken
// and yields exactly one result beat: the pin levels and pwm step after that
// command. The block takes one command per cycle for as long as the result
// side keeps up; the single result register is the only storage between the
// channels, so in_stall follows out_stall while a result is held. Select
// latches the active motor mask; motor commands act on all active motors at
// once. A tick advances the pwm step from 0 to 254 and wraps. Only motors 0
// to 3 appear on the pin ports.
module multi_motor_pwm_hbridge_controller
  import mmpwm_pkg::*;
#(
  parameter int MOTORS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_cmd,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_cw_pins,
  output logic [3:0] out_ccw_pins,
  output logic [3:0] out_enable_pins,
  output logic       out_group_ab_enable,
  output logic       out_group_cd_enable,
  output logic [7:0] out_pwm_step
);

  logic              out_valid_r, out_valid_nxt;
  logic [MOTORS-1:0] active_r, active_nxt;
  logic [7:0]        step_r, step_nxt;
  logic [1:0]        group_r, group_nxt;
  logic              in_acc;
  logic [MOTORS-1:0] on_vec;
  logic [MOTORS-1:0] en_vec;
  logic [MOTORS-1:0] grp_clr;
  motor_ctl_t        ctl;
  motor_stat_t       stat [MOTORS];

  // handshake
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign out_valid_nxt = in_acc ? 1'b1 : (out_valid_r && out_stall);

  // broadcast to motor cells
  assign ctl.go    = in_acc;
  assign ctl.cmd   = in_cmd;
  assign ctl.value = in_value;
  assign ctl.step  = step_r;

  // motor cells
  for (genvar i = 0; i < MOTORS; i++) begin : g_motor
    mmpwm_motor u_motor (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sel   (active_r[i]),
      .stat  (stat[i])
    );
    assign on_vec[i] = stat[i].on;
    assign en_vec[i] = stat[i].en;
  end

  // off: a group enable drops only if the partner is off, counting a lower
  // partner that this same command switches off
  for (genvar i = 0; i < MOTORS; i++) begin : g_partner
    if ((i ^ 1) < MOTORS) begin : g_has
      if ((i ^ 1) < i) begin : g_low
        assign grp_clr[i] = active_r[i] && (!on_vec[i ^ 1] || active_r[i ^ 1]);
      end else begin : g_high
        assign grp_clr[i] = active_r[i] && !on_vec[i ^ 1];
      end
    end else begin : g_none
      assign grp_clr[i] = active_r[i];
    end
  end

  // shared state update
  always_comb begin
    active_nxt = active_r;
    step_nxt   = step_r;
    group_nxt  = group_r;
    if (in_acc) begin
      unique case (in_cmd)
        CMD_TICK: begin
          step_nxt = (step_r == PWM_LAST_STEP) ? 8'd0 : step_r + 8'd1;
        end
        CMD_SELECT: begin
          active_nxt = in_value[MOTORS-1:0];
        end
        CMD_ON, CMD_SERVO: begin
          if (|active_r) begin
            group_nxt = 2'b11;
          end
        end
        CMD_OFF: begin
          if (|grp_clr[1:0]) begin
            group_nxt[0] = 1'b0;
          end
          if (|(grp_clr >> 2)) begin
            group_nxt[1] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= '0;
      step_r      <= 8'd0;
      group_r     <= 2'b00;
    end else begin
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      step_r      <= step_nxt;
      group_r     <= group_nxt;
    end
  end

  // result beat: state only moves on an accepted beat, so it holds under stall
  for (genvar k = 0; k < 4; k++) begin : g_pins
    if (k < MOTORS) begin : g_used
      assign out_cw_pins[k]     = stat[k].cw;
      assign out_ccw_pins[k]    = stat[k].ccw;
      assign out_enable_pins[k] = stat[k].en;
    end else begin : g_unused
      assign out_cw_pins[k]     = 1'b0;
      assign out_ccw_pins[k]    = 1'b0;
      assign out_enable_pins[k] = 1'b0;
    end
  end

  assign out_group_ab_enable = group_r[0];
  assign out_group_cd_enable = group_r[1];
  assign out_pwm_step        = step_r;

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= PWM_LAST_STEP)
    else $error("pwm step out of range");

  a_step_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_TICK) |=>
      step_r == (($past(step_r) == PWM_LAST_STEP) ? 8'd0 : $past(step_r) + 8'd1))
    else $error("pwm step did not advance on tick");

  a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_cmd == CMD_TICK) |=> $stable(step_r))
    else $error("pwm step moved without a tick");

  a_on_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (on_vec & ~en_vec) == '0)
    else $error("motor on with enable low");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !in_acc) |=> !out_valid_r)
    else $error("result beat repeated");

endmodule
